// ----- sv/cia_pkg.sv -----
// shared types, op codes and saturation helpers for the composite inertia block
`timescale 1ns / 1ps

package cia_pkg;

    // default part capacity
    localparam int MAX_PARTS = 64;

    // restoring divider: one quotient bit per cycle over an 80-bit dividend
    localparam int DIV_STEPS = 80;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // multiplier op codes, product goes to the matching accumulator or offset product slot
    typedef logic [3:0] t_op;
    localparam t_op OP_MX  = 4'd0;
    localparam t_op OP_MY  = 4'd1;
    localparam t_op OP_MZ  = 4'd2;
    localparam t_op OP_DXX = 4'd3;
    localparam t_op OP_DYY = 4'd4;
    localparam t_op OP_DZZ = 4'd5;
    localparam t_op OP_DXY = 4'd6;
    localparam t_op OP_DXZ = 4'd7;
    localparam t_op OP_DYZ = 4'd8;
    localparam t_op OP_T0  = 4'd9;
    localparam t_op OP_T1  = 4'd10;
    localparam t_op OP_T2  = 4'd11;
    localparam t_op OP_T3  = 4'd12;
    localparam t_op OP_T4  = 4'd13;
    localparam t_op OP_T5  = 4'd14;

    // controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       mul_en;
        t_op        op;
        logic       com_load;
        logic       div_step;
        logic       com_wr;
        logic [1:0] axis;
        logic       rd;
        logic       diff;
        logic       shift;
        logic       emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic norm;
        logic tp_end;
    } t_dp_sts;

    // clamp a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // flag for a value that sat32 would clamp
    function automatic logic is_sat(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

endpackage

// ----- sv/composite_inertia_assembly_top.sv -----
// top level: composite inertia assembly, Q16.16, parts in, one result per assembly
// busy stays high while a stored part's moment products are issued; after the last part
// come its products (skipped if it is dropped), per axis a centre load, the 80-step divider and
// a centre write if the mass sum exceeds min_mass, per stored part offsets, offset and tensor
// products, then the result; one assembly at a time; no receiver stall; strobe lasts one cycle
// synchronous active-low reset empties the part store; min_mass resets to 1
`timescale 1ns / 1ps

module composite_inertia_assembly_top #(
    parameter int MAX_PARTS = cia_pkg::MAX_PARTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_min_mass_we,
    input  logic [31:0]        i_min_mass,
    input  logic [31:0]        i_mass,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_in_xx,
    input  logic signed [31:0] i_in_yy,
    input  logic signed [31:0] i_in_zz,
    input  logic signed [31:0] i_in_xy,
    input  logic signed [31:0] i_in_xz,
    input  logic signed [31:0] i_in_yz,
    input  logic               i_last_part,
    output logic               o_valid,
    output logic [31:0]        o_sum_mass,
    output logic signed [31:0] o_com_x,
    output logic signed [31:0] o_com_y,
    output logic signed [31:0] o_com_z,
    output logic signed [31:0] o_out_xx,
    output logic signed [31:0] o_out_yy,
    output logic signed [31:0] o_out_zz,
    output logic signed [31:0] o_out_xy,
    output logic signed [31:0] o_out_xz,
    output logic signed [31:0] o_out_yz,
    output logic               o_overflow
);

    cia_pkg::t_dp_cmd cmd;
    cia_pkg::t_dp_sts sts;

    // sequencing
    cia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_part (i_last_part),
        .i_sts       (sts),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    // arithmetic and storage
    cia_datapath #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_min_mass_we (i_min_mass_we),
        .i_min_mass    (i_min_mass),
        .i_mass        (i_mass),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_in_xx       (i_in_xx),
        .i_in_yy       (i_in_yy),
        .i_in_zz       (i_in_zz),
        .i_in_xy       (i_in_xy),
        .i_in_xz       (i_in_xz),
        .i_in_yz       (i_in_yz),
        .o_valid       (o_valid),
        .o_sum_mass    (o_sum_mass),
        .o_com_x       (o_com_x),
        .o_com_y       (o_com_y),
        .o_com_z       (o_com_z),
        .o_out_xx      (o_out_xx),
        .o_out_yy      (o_out_yy),
        .o_out_zz      (o_out_zz),
        .o_out_xy      (o_out_xy),
        .o_out_xz      (o_out_xz),
        .o_out_yz      (o_out_yz),
        .o_overflow    (o_overflow)
    );

endmodule

// ----- sv/cia_datapath.sv -----
// datapath: part store, shared multiplier, centre divider and accumulators
`timescale 1ns / 1ps

module cia_datapath #(
    parameter int MAX_PARTS = cia_pkg::MAX_PARTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cia_pkg::t_dp_cmd    i_cmd,
    output cia_pkg::t_dp_sts    o_sts,
    input  logic                i_min_mass_we,
    input  logic [31:0]         i_min_mass,
    input  logic [31:0]         i_mass,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_in_xx,
    input  logic signed [31:0]  i_in_yy,
    input  logic signed [31:0]  i_in_zz,
    input  logic signed [31:0]  i_in_xy,
    input  logic signed [31:0]  i_in_xz,
    input  logic signed [31:0]  i_in_yz,
    output logic                o_valid,
    output logic [31:0]         o_sum_mass,
    output logic signed [31:0]  o_com_x,
    output logic signed [31:0]  o_com_y,
    output logic signed [31:0]  o_com_z,
    output logic signed [31:0]  o_out_xx,
    output logic signed [31:0]  o_out_yy,
    output logic signed [31:0]  o_out_zz,
    output logic signed [31:0]  o_out_xy,
    output logic signed [31:0]  o_out_xz,
    output logic signed [31:0]  o_out_yz,
    output logic                o_overflow
);

    localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int WW = 320;

    // control state
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic                r_dropped;
    logic                r_ov;
    logic [31:0]         r_min_mass;
    logic [63:0]         r_mass_sum;
    logic signed [63:0]  r_moment [3];
    logic signed [63:0]  r_tensor [6];
    logic                r_acc_en;
    cia_pkg::t_op        r_acc_op;
    logic                r_valid;

    // payload state
    logic [WW-1:0]       r_mem [MAX_PARTS];
    logic [WW-1:0]       r_rd;
    logic [31:0]         r_in_mass;
    logic signed [31:0]  r_in_pos [3];
    logic signed [67:0]  r_prod;
    logic signed [32:0]  r_d [3];
    logic signed [63:0]  r_dp [6];
    logic signed [31:0]  r_sh [6];
    logic signed [31:0]  r_com [3];
    logic [63:0]         r_div_r;
    logic [79:0]         r_div_q;
    logic                r_div_neg;

    logic                full;
    logic [31:0]         rd_mass;
    logic signed [33:0]  mul_a;
    logic signed [33:0]  mul_b;
    logic signed [67:0]  prod;
    logic signed [63:0]  prod_q;
    logic [2:0]          t_k;
    logic [2:0]          acc_k;
    logic signed [63:0]  sh64 [6];
    logic signed [63:0]  mom;
    logic [63:0]         mom_mag;
    logic [64:0]         div_rs;
    logic                div_ge;
    logic signed [63:0]  q_val;
    logic                q_big;
    logic signed [31:0]  com_div;
    logic                com_div_ov;
    logic                sh_ov;
    logic                ten_ov;

    assign full          = (r_count == CW'(MAX_PARTS));
    assign o_sts.full    = full;
    assign o_sts.norm    = r_mass_sum > {32'd0, r_min_mass};
    assign o_sts.tp_end  = (r_idx == r_count);
    assign rd_mass       = r_rd[31:0];
    assign o_valid       = r_valid;

    // part store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_in_yz, i_in_xz, i_in_xy, i_in_zz, i_in_yy,
                                       i_in_xx, i_pos_z, i_pos_y, i_pos_x, i_mass};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    // multiplier operand select
    always_comb begin
        t_k   = 3'(i_cmd.op - cia_pkg::OP_T0);
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            cia_pkg::OP_MX, cia_pkg::OP_MY, cia_pkg::OP_MZ: begin
                mul_a = {{2{r_in_pos[i_cmd.op[1:0]][31]}}, r_in_pos[i_cmd.op[1:0]]};
                mul_b = {2'b00, r_in_mass};
            end
            cia_pkg::OP_DXX: begin
                mul_a = {r_d[0][32], r_d[0]};
                mul_b = {r_d[0][32], r_d[0]};
            end
            cia_pkg::OP_DYY: begin
                mul_a = {r_d[1][32], r_d[1]};
                mul_b = {r_d[1][32], r_d[1]};
            end
            cia_pkg::OP_DZZ: begin
                mul_a = {r_d[2][32], r_d[2]};
                mul_b = {r_d[2][32], r_d[2]};
            end
            cia_pkg::OP_DXY: begin
                mul_a = {r_d[0][32], r_d[0]};
                mul_b = {r_d[1][32], r_d[1]};
            end
            cia_pkg::OP_DXZ: begin
                mul_a = {r_d[0][32], r_d[0]};
                mul_b = {r_d[2][32], r_d[2]};
            end
            cia_pkg::OP_DYZ: begin
                mul_a = {r_d[1][32], r_d[1]};
                mul_b = {r_d[2][32], r_d[2]};
            end
            cia_pkg::OP_T0, cia_pkg::OP_T1, cia_pkg::OP_T2,
            cia_pkg::OP_T3, cia_pkg::OP_T4, cia_pkg::OP_T5: begin
                mul_a = {{2{r_sh[t_k][31]}}, r_sh[t_k]};
                mul_b = {2'b00, rd_mass};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // exact product, floor to q16.16 after the register
    assign prod   = mul_a * mul_b;
    assign prod_q = {{12{r_prod[67]}}, r_prod[67:16]};
    assign acc_k  = 3'(r_acc_op - cia_pkg::OP_T0);

    // shift tensor from the offset products
    always_comb begin
        sh64[0] = r_dp[1] + r_dp[2];
        sh64[1] = r_dp[0] + r_dp[2];
        sh64[2] = r_dp[0] + r_dp[1];
        sh64[3] = -r_dp[3];
        sh64[4] = -r_dp[4];
        sh64[5] = -r_dp[5];
        sh_ov   = 1'b0;
        for (int k = 0; k < 6; k++) begin
            sh_ov = sh_ov | cia_pkg::is_sat(sh64[k]);
        end
    end

    // centre: magnitude for the divider, divider step, quotient clamp
    always_comb begin
        mom        = r_moment[i_cmd.axis];
        mom_mag    = mom[63] ? 64'(-mom) : 64'(mom);
        div_rs     = {r_div_r, r_div_q[79]};
        div_ge     = div_rs >= {1'b0, r_mass_sum};
        q_big      = |r_div_q[79:32];
        q_val      = r_div_neg ? -$signed({32'd0, r_div_q[31:0]})
                               : $signed({32'd0, r_div_q[31:0]});
        com_div    = q_big ? (r_div_neg ? 32'sh80000000 : 32'sh7FFFFFFF)
                           : cia_pkg::sat32(q_val);
        com_div_ov = q_big | cia_pkg::is_sat(q_val);
    end

    // saturation of the finished tensor sums
    always_comb begin
        ten_ov = 1'b0;
        for (int k = 0; k < 6; k++) begin
            ten_ov = ten_ov | cia_pkg::is_sat(r_tensor[k]);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_mass   <= i_mass;
            r_in_pos[0] <= i_pos_x;
            r_in_pos[1] <= i_pos_y;
            r_in_pos[2] <= i_pos_z;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        // offset products land in their slots
        if (r_acc_en && r_acc_op >= cia_pkg::OP_DXX && r_acc_op <= cia_pkg::OP_DYZ) begin
            r_dp[3'(r_acc_op - cia_pkg::OP_DXX)] <= prod_q;
        end
        if (i_cmd.diff) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= {r_rd[32 + 32*k + 31], r_rd[32 + 32*k +: 32]}
                          - {r_com[k][31], r_com[k]};
            end
        end
        if (i_cmd.shift) begin
            for (int k = 0; k < 6; k++) begin
                r_sh[k] <= cia_pkg::sat32(sh64[k]);
            end
        end
        // centre divider
        if (i_cmd.com_load) begin
            r_div_r   <= '0;
            r_div_q   <= {mom_mag, 16'd0};
            r_div_neg <= mom[63];
            if (!o_sts.norm) begin
                r_com[i_cmd.axis] <= cia_pkg::sat32(mom);
            end
        end
        if (i_cmd.div_step) begin
            r_div_r <= div_ge ? 64'(div_rs - {1'b0, r_mass_sum}) : div_rs[63:0];
            r_div_q <= {r_div_q[78:0], div_ge};
        end
        if (i_cmd.com_wr) begin
            r_com[i_cmd.axis] <= com_div;
        end
        // result registers
        if (i_cmd.emit) begin
            o_sum_mass   <= (|r_mass_sum[63:32]) ? 32'hFFFFFFFF : r_mass_sum[31:0];
            o_com_x      <= r_com[0];
            o_com_y      <= r_com[1];
            o_com_z      <= r_com[2];
            o_out_xx     <= cia_pkg::sat32(r_tensor[0]);
            o_out_yy     <= cia_pkg::sat32(r_tensor[1]);
            o_out_zz     <= cia_pkg::sat32(r_tensor[2]);
            o_out_xy     <= cia_pkg::sat32(r_tensor[3]);
            o_out_xz     <= cia_pkg::sat32(r_tensor[4]);
            o_out_yz     <= cia_pkg::sat32(r_tensor[5]);
            o_overflow   <= r_ov | r_dropped | (|r_mass_sum[63:32]) | ten_ov;
        end
    end

    // counters, sums and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_dropped  <= 1'b0;
            r_ov       <= 1'b0;
            r_min_mass <= 32'd1;
            r_mass_sum <= '0;
            r_acc_en   <= 1'b0;
            r_acc_op   <= cia_pkg::OP_MX;
            r_valid    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_moment[k] <= '0;
            end
            for (int k = 0; k < 6; k++) begin
                r_tensor[k] <= '0;
            end
        end else begin
            r_valid  <= i_cmd.emit;
            r_acc_en <= i_cmd.mul_en;
            r_acc_op <= i_cmd.op;
            if (i_min_mass_we) begin
                r_min_mass <= i_min_mass;
            end
            // store a part or drop it when full
            if (i_cmd.accept) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count    <= r_count + CW'(1);
                    r_mass_sum <= r_mass_sum + {32'd0, i_mass};
                end
            end
            // accumulate the registered product, plus the stored part's own term for the tensor sums
            if (r_acc_en) begin
                if (r_acc_op <= cia_pkg::OP_MZ) begin
                    r_moment[r_acc_op[1:0]] <= r_moment[r_acc_op[1:0]] + prod_q;
                end else if (r_acc_op >= cia_pkg::OP_T0 && r_acc_op <= cia_pkg::OP_T5) begin
                    r_tensor[acc_k] <= r_tensor[acc_k]
                        + {{32{r_rd[128 + 32*acc_k + 31]}}, r_rd[128 + 32*acc_k +: 32]}
                        + prod_q;
                end
            end
            if (i_cmd.rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.com_load && !o_sts.norm && cia_pkg::is_sat(mom)) begin
                r_ov <= 1'b1;
            end
            if (i_cmd.com_wr && com_div_ov) begin
                r_ov <= 1'b1;
            end
            if (i_cmd.shift && sh_ov) begin
                r_ov <= 1'b1;
            end
            // back to empty after the result
            if (i_cmd.emit) begin
                r_count    <= '0;
                r_idx      <= '0;
                r_dropped  <= 1'b0;
                r_ov       <= 1'b0;
                r_mass_sum <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_moment[k] <= '0;
                end
                for (int k = 0; k < 6; k++) begin
                    r_tensor[k] <= '0;
                end
            end
        end
    end

    // checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PARTS))
        else $error("part count above capacity");

    a_idx_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("walk index past stored parts");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_valid && r_count == '0 && r_mass_sum == '0)
        else $error("result strobe or clear missing after emit");

    a_no_rd_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> !o_sts.tp_end)
        else $error("read beyond stored parts");

endmodule

// ----- sv/cia_ctrl.sv -----
// controller: load, centre, tensor walk and result sequencing
`timescale 1ns / 1ps

module cia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last_part,
    input  cia_pkg::t_dp_sts  i_sts,
    output logic              o_busy,
    output cia_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOM   = 4'd1;
    localparam logic [3:0] S_CLD   = 4'd2;
    localparam logic [3:0] S_CDIV  = 4'd3;
    localparam logic [3:0] S_CWR   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_DIFF  = 4'd6;
    localparam logic [3:0] S_DMUL  = 4'd7;
    localparam logic [3:0] S_DWAIT = 4'd8;
    localparam logic [3:0] S_SHIFT = 4'd9;
    localparam logic [3:0] S_TMUL  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]                  r_state, n_state;
    logic [cia_pkg::DIV_CW-1:0]  r_step,  n_step;
    logic [1:0]                  r_axis,  n_axis;
    logic                        r_last,  n_last;

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_step = '0;
                    n_axis = '0;
                    n_last = i_last_part;
                    if (!i_sts.full) begin
                        n_state = S_MOM;
                    end else if (i_last_part) begin
                        n_state = S_CLD;
                    end
                end
            end
            S_MOM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op = cia_pkg::OP_MX + cia_pkg::t_op'(r_step);
                if (r_step == cia_pkg::DIV_CW'(2)) begin
                    n_step  = '0;
                    n_state = r_last ? S_CLD : S_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CLD: begin
                o_cmd.com_load = 1'b1;
                n_step = '0;
                if (i_sts.norm) begin
                    n_state = S_CDIV;
                end else if (r_axis == 2'd2) begin
                    n_state = S_RD;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_CDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == cia_pkg::DIV_CW'(cia_pkg::DIV_STEPS - 1)) begin
                    n_state = S_CWR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CWR: begin
                o_cmd.com_wr = 1'b1;
                if (r_axis == 2'd2) begin
                    n_state = S_RD;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_CLD;
                end
            end
            S_RD: begin
                n_step = '0;
                if (i_sts.tp_end) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op = cia_pkg::OP_DXX + cia_pkg::t_op'(r_step);
                if (r_step == cia_pkg::DIV_CW'(5)) begin
                    n_step  = '0;
                    n_state = S_DWAIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DWAIT: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op = cia_pkg::OP_T0 + cia_pkg::t_op'(r_step);
                if (r_step == cia_pkg::DIV_CW'(5)) begin
                    n_step  = '0;
                    n_state = S_RD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_axis  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
            r_last  <= n_last;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the composite inertia assembly: directed and random part streams checked against a predictor
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_PARTS   = cia_pkg::MAX_PARTS;
    localparam int CYCLE_LIMIT = 3000000;

    // one part request
    typedef struct {
        logic [31:0]        mass;
        logic signed [31:0] pos[3];
        logic signed [31:0] ten[6];
        logic               last;
    } t_part;

    // one assembly result
    typedef struct {
        logic [31:0]        sum_mass;
        logic signed [31:0] com[3];
        logic signed [31:0] ten[6];
        logic               overflow;
    } t_assembly;

    // predictor of the assembly and store of pending assembly results
    class inertia_scoreboard;
        bit [31:0]           min_mass;
        int                  part_cnt;
        bit                  parts_lost;
        bit [31:0]           mass_mem[MAX_PARTS];
        longint              pos_mem[MAX_PARTS][3];
        longint              ten_mem[MAX_PARTS][6];
        longint unsigned     mass_acc;
        longint              moment_acc[3];
        t_assembly           pending[$];
        int                  errors;

        function new();
            min_mass = 1;
            errors = 0;
            clear();
        endfunction

        function void clear();
            part_cnt = 0;
            parts_lost = 0;
            mass_acc = 0;
            foreach (moment_acc[k]) moment_acc[k] = 0;
        endfunction

        // Q16.16 product, floor
        function longint mulq(longint a, longint b);
            logic signed [127:0] pa, pb, pr;
            pa = a;
            pb = b;
            pr = pa * pb;
            return longint'(pr >>> 16);
        endfunction

        function longint clamp(longint v, inout bit ov);
            if (v > 64'sd2147483647) begin
                ov = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                ov = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // centre division, truncated toward zero
        function longint centre(longint mom, longint unsigned m, inout bit ov);
            longint unsigned a, q1, r, q;
            a = (mom < 0) ? longint'(-mom) : longint'(mom);
            q1 = a / m;
            r = a % m;
            if (q1 >= 65536) q = 64'd1 << 48;
            else q = (q1 << 16) + (r << 16) / m;
            return clamp((mom < 0) ? -longint'(q) : longint'(q), ov);
        endfunction

        function void note(t_part p);
            bit        ov;
            longint    com[3], d[3], sh[6], acc[6];
            t_assembly res;
            if (part_cnt < MAX_PARTS) begin
                mass_mem[part_cnt] = p.mass;
                mass_acc += p.mass;
                for (int k = 0; k < 3; k++) begin
                    pos_mem[part_cnt][k] = p.pos[k];
                    moment_acc[k] += mulq(p.pos[k], longint'(p.mass));
                end
                for (int k = 0; k < 6; k++) ten_mem[part_cnt][k] = p.ten[k];
                part_cnt++;
            end else begin
                parts_lost = 1;
            end
            if (!p.last) return;
            ov = 0;
            for (int k = 0; k < 3; k++) begin
                if (mass_acc > longint'(min_mass)) com[k] = centre(moment_acc[k], mass_acc, ov);
                else com[k] = clamp(moment_acc[k], ov);
            end
            foreach (acc[k]) acc[k] = 0;
            // parallel axis shift of every stored part
            for (int i = 0; i < part_cnt; i++) begin
                for (int k = 0; k < 3; k++) d[k] = pos_mem[i][k] - com[k];
                sh[0] = mulq(d[1], d[1]) + mulq(d[2], d[2]);
                sh[1] = mulq(d[0], d[0]) + mulq(d[2], d[2]);
                sh[2] = mulq(d[0], d[0]) + mulq(d[1], d[1]);
                sh[3] = -mulq(d[0], d[1]);
                sh[4] = -mulq(d[0], d[2]);
                sh[5] = -mulq(d[1], d[2]);
                for (int k = 0; k < 6; k++)
                    acc[k] += ten_mem[i][k] + mulq(clamp(sh[k], ov), longint'(mass_mem[i]));
            end
            if (mass_acc > 64'hFFFFFFFF) begin
                ov = 1;
                res.sum_mass = 32'hFFFFFFFF;
            end else begin
                res.sum_mass = mass_acc[31:0];
            end
            for (int k = 0; k < 3; k++) res.com[k] = com[k][31:0];
            for (int k = 0; k < 6; k++) res.ten[k] = 32'(clamp(acc[k], ov));
            res.overflow = ov | parts_lost;
            pending.push_back(res);
            clear();
        endfunction

        function void check(t_assembly r);
            t_assembly e;
            string     com_names[3];
            string     ten_names[6];
            com_names = '{"com_x", "com_y", "com_z"};
            ten_names = '{"out_xx", "out_yy", "out_zz", "out_xy", "out_xz", "out_yz"};
            if (pending.size() == 0) begin
                $error("unexpected result, sum_mass %h", r.sum_mass);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.sum_mass !== e.sum_mass) begin
                $error("sum_mass exp %h got %h", e.sum_mass, r.sum_mass);
                errors++;
            end
            for (int k = 0; k < 3; k++)
                if (r.com[k] !== e.com[k]) begin
                    $error("%s exp %h got %h", com_names[k], e.com[k], r.com[k]);
                    errors++;
                end
            for (int k = 0; k < 6; k++)
                if (r.ten[k] !== e.ten[k]) begin
                    $error("%s exp %h got %h", ten_names[k], e.ten[k], r.ten[k]);
                    errors++;
                end
            if (r.overflow !== e.overflow) begin
                $error("overflow exp %b got %b", e.overflow, r.overflow);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_min_mass_we;
    logic [31:0]        i_min_mass;
    logic [31:0]        i_mass;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_in_xx, i_in_yy, i_in_zz, i_in_xy, i_in_xz, i_in_yz;
    logic               i_last_part;
    logic               o_valid;
    logic [31:0]        o_sum_mass;
    logic signed [31:0] o_com_x, o_com_y, o_com_z;
    logic signed [31:0] o_out_xx, o_out_yy, o_out_zz, o_out_xy, o_out_xz, o_out_yz;
    logic               o_overflow;

    inertia_scoreboard sb = new();
    int  cycles = 0;
    bit  no_gaps = 0;
    int  sent = 0;

    composite_inertia_assembly_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_min_mass_we(i_min_mass_we), .i_min_mass(i_min_mass),
        .i_mass(i_mass), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_in_xx(i_in_xx), .i_in_yy(i_in_yy), .i_in_zz(i_in_zz),
        .i_in_xy(i_in_xy), .i_in_xz(i_in_xz), .i_in_yz(i_in_yz),
        .i_last_part(i_last_part), .o_valid(o_valid), .o_sum_mass(o_sum_mass),
        .o_com_x(o_com_x), .o_com_y(o_com_y), .o_com_z(o_com_z),
        .o_out_xx(o_out_xx), .o_out_yy(o_out_yy), .o_out_zz(o_out_zz),
        .o_out_xy(o_out_xy), .o_out_xz(o_out_xz), .o_out_yz(o_out_yz),
        .o_overflow(o_overflow)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[composite_inertia_assembly_top] ERROR");
            $finish;
        end
    end

    // result capture
    always @(posedge i_clk) begin
        t_assembly r;
        if (i_rst_n && o_valid) begin
            r.sum_mass = o_sum_mass;
            r.com[0] = o_com_x;
            r.com[1] = o_com_y;
            r.com[2] = o_com_z;
            r.ten[0] = o_out_xx;
            r.ten[1] = o_out_yy;
            r.ten[2] = o_out_zz;
            r.ten[3] = o_out_xy;
            r.ten[4] = o_out_xz;
            r.ten[5] = o_out_yz;
            r.overflow = o_overflow;
            sb.check(r);
        end
    end

    // issue one part request and wait for it to be taken
    task automatic send_part(t_part p);
        if (!no_gaps && $urandom_range(99) < 23) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_mass      <= p.mass;
        i_pos_x     <= p.pos[0];
        i_pos_y     <= p.pos[1];
        i_pos_z     <= p.pos[2];
        i_in_xx     <= p.ten[0];
        i_in_yy     <= p.ten[1];
        i_in_zz     <= p.ten[2];
        i_in_xy     <= p.ten[3];
        i_in_xz     <= p.ten[4];
        i_in_yz     <= p.ten[5];
        i_last_part <= p.last;
        do @(posedge i_clk); while (busy);
        sb.note(p);
        sent++;
    endtask

    // write min_mass once the block has drained
    task automatic write_min_mass(logic [31:0] v);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_min_mass_we <= 1'b1;
        i_min_mass    <= v;
        @(posedge i_clk);
        i_min_mass_we <= 1'b0;
        sb.min_mass = v;
    endtask

    function automatic logic [31:0] rand_signed();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            2: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic t_part rand_part(logic last);
        t_part p;
        case ($urandom_range(4))
            0: p.mass = $urandom;
            1: p.mass = $urandom_range(0, 3);
            default: p.mass = $urandom_range(0, 32'h0010_0000);
        endcase
        foreach (p.pos[k]) p.pos[k] = rand_signed();
        foreach (p.ten[k]) p.ten[k] = rand_signed();
        p.last = last;
        return p;
    endfunction

    function automatic t_part fixed_part(logic [31:0] m, logic [31:0] ps, logic [31:0] t,
                                         logic last);
        t_part p;
        p.mass = m;
        foreach (p.pos[k]) p.pos[k] = ps;
        foreach (p.ten[k]) p.ten[k] = t;
        p.last = last;
        return p;
    endfunction

    // one assembly of n parts, last flag on the final one
    task automatic send_assembly(int n);
        for (int i = 0; i < n; i++) send_part(rand_part(i == n - 1));
    endtask

    initial begin
        int n;
        int asm_cnt;
        logic [31:0] settings[5];
        settings      = '{32'd0, 32'hFFFFFFFF, 32'h0001_0000, 32'd1, 32'd0};
        start         = 0;
        i_rst_n       = 0;
        i_min_mass_we = 0;
        i_min_mass    = 0;
        i_mass        = 0;
        i_pos_x       = 0;
        i_pos_y       = 0;
        i_pos_z       = 0;
        i_in_xx       = 0;
        i_in_yy       = 0;
        i_in_zz       = 0;
        i_in_xy       = 0;
        i_in_xz       = 0;
        i_in_yz       = 0;
        i_last_part   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero mass, mass not above min_mass gives raw moment centre
        send_part(fixed_part(32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
        send_part(fixed_part(32'd1, 32'h7FFFFFFF, 32'h80000000, 1'b1));
        // extreme mass and positions, saturating centre and tensor
        send_part(fixed_part(32'hFFFFFFFF, 32'h80000000, 32'h80000000, 1'b1));
        send_part(fixed_part(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
        send_part(fixed_part(32'hFFFFFFFF, 32'h80000000, 32'h00000000, 1'b1));
        // opposite parts, centre at the origin
        send_part(fixed_part(32'h0001_0000, 32'h0002_0000, 32'h0000_1000, 1'b0));
        send_part(fixed_part(32'h0001_0000, 32'hFFFE_0000, 32'hFFFF_F000, 1'b1));
        // negative moment with truncating division
        send_part(fixed_part(32'h0003_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
        send_part(fixed_part(32'h0000_0007, 32'h0000_0005, 32'h0000_0000, 1'b1));
        // capacity full, last flag on a discarded part
        for (int i = 0; i < MAX_PARTS + 2; i++)
            send_part(rand_part(i == MAX_PARTS + 1));
        write_min_mass(32'hFFFFFFFF);
        send_part(fixed_part(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0100, 1'b0));
        send_part(fixed_part(32'h0002_0000, 32'hFFFF_0000, 32'h0000_0100, 1'b1));

        // random assemblies over several min_mass settings
        asm_cnt = 0;
        while (sent < 1945) begin
            if (asm_cnt % 40 == 39) begin
                if ($urandom_range(1)) write_min_mass(settings[(asm_cnt / 40) % 5]);
                else write_min_mass($urandom);
            end
            no_gaps = (asm_cnt >= 100 && asm_cnt < 130);
            case ($urandom_range(19))
                0: n = $urandom_range(MAX_PARTS - 2, MAX_PARTS + 4);
                1, 2: n = $urandom_range(9, 24);
                default: n = $urandom_range(1, 8);
            endcase
            send_assembly(n);
            asm_cnt++;
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[composite_inertia_assembly_top] OK");
        end else begin
            $display("[composite_inertia_assembly_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cia_pkg.sv
sv/cia_datapath.sv
sv/cia_ctrl.sv
sv/composite_inertia_assembly_top.sv
tb/sv/testbench.sv
